// ===== hdl/axis_angle_to_rotation_matrix_macros.svh =====
// ----------------------------------------------------------------------------
// axis angle to rotation matrix assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define AAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("aar check failed");

// implication after a fixed number of cycles
`define AAR_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("aar latency check failed");

`endif

// ===== hdl/aar_pkg.sv =====
// ----------------------------------------------------------------------------
// aar_pkg
// types and constants of the axis angle to rotation matrix pipeline
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam int FracBits    = 14;
  localparam int CordicSteps = FracBits + 1;
  localparam int SqrtSteps   = 17;
  localparam int DivSteps    = 15;
  localparam int OutOne      = 16384;

  // cordic start value: gain rounded to q14, the working format
  localparam logic signed [17:0] CordicX0 = 18'sd9949;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] turn_angle;
  } item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } result_t;

  // binary angle arctangent, 2^32 units per turn
  function automatic logic signed [32:0] atan_at(input logic [3:0] idx);
    logic signed [32:0] a;
    case (idx)
      4'd0:    a = 33'sd536870912;
      4'd1:    a = 33'sd316933406;
      4'd2:    a = 33'sd167458907;
      4'd3:    a = 33'sd85004756;
      4'd4:    a = 33'sd42667331;
      4'd5:    a = 33'sd21354465;
      4'd6:    a = 33'sd10679838;
      4'd7:    a = 33'sd5340245;
      4'd8:    a = 33'sd2670163;
      4'd9:    a = 33'sd1335087;
      4'd10:   a = 33'sd667544;
      4'd11:   a = 33'sd333772;
      4'd12:   a = 33'sd166886;
      4'd13:   a = 33'sd83443;
      4'd14:   a = 33'sd41722;
      default: a = 33'sd20861;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/axis_angle_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// a result strobes on done_o once the start transfer has passed every stage
// throughput: one transfer per cycle, busy stays low, nothing stalls
// most stages are one cordic step, one root step or one divide step
// reset clears only the valid line; payload registers are not reset
// the receiver cannot stall, so results are never held back
// ----------------------------------------------------------------------------
`include "axis_angle_to_rotation_matrix_macros.svh"

module axis_angle_to_rotation_matrix import aar_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  // stage layout of the valid line
  localparam int Lat = 1 + CordicSteps + 3 + SqrtSteps + 1 + DivSteps + 2;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [32:0] z;
    logic               up;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } cord_t;

  typedef struct packed {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] z;
    logic signed [18:0] w;
  } quat_t;

  typedef struct packed {
    logic [33:0] n;
    logic [33:0] res;
    quat_t       q;
  } root_t;

  typedef struct packed {
    logic [3:0][33:0] rem;
    logic [3:0][14:0] qt;
    logic [3:0]       neg;
    logic [17:0]      d;
    logic             zero;
  } div_t;

  typedef struct packed {
    logic signed [32:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  } prod_t;

  logic [Lat-1:0] vld_q;
  cord_t          cord_q [CordicSteps+1];
  cord_t          cord_d [CordicSteps+1];
  quat_t          quat_q;
  quat_t          quat_d;
  logic [3:0][32:0] sq_q;
  logic [3:0][32:0] sq_d;
  quat_t          sqq_q;
  root_t          root_q [SqrtSteps+1];
  root_t          root_d [SqrtSteps+1];
  div_t           div_q [DivSteps+1];
  div_t           div_d [DivSteps+1];
  prod_t          prod_q;
  prod_t          prod_d;
  result_t        res_q;
  result_t        res_d;

  // never busy: one transfer per cycle
  assign busy = 1'b0;

  // valid line, one bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start & ~busy};
    end
  end

  // input stage: half angle folded into the first quarter turn
  // then cordic rotation, one step per stage
  always_comb begin
    cord_d[0].x  = CordicX0;
    cord_d[0].y  = '0;
    cord_d[0].z  = $signed({3'b000, item_i.turn_angle[14:0], 15'd0});
    cord_d[0].up = item_i.turn_angle[15];
    cord_d[0].ax = item_i.axis_x;
    cord_d[0].ay = item_i.axis_y;
    cord_d[0].az = item_i.axis_z;
    for (int i = 0; i < CordicSteps; i++) begin
      cord_d[i+1] = cord_q[i];
      if (!cord_q[i].z[32]) begin
        cord_d[i+1].x = cord_q[i].x - (cord_q[i].y >>> i);
        cord_d[i+1].y = cord_q[i].y + (cord_q[i].x >>> i);
        cord_d[i+1].z = cord_q[i].z - atan_at(4'(i));
      end else begin
        cord_d[i+1].x = cord_q[i].x + (cord_q[i].y >>> i);
        cord_d[i+1].y = cord_q[i].y - (cord_q[i].x >>> i);
        cord_d[i+1].z = cord_q[i].z + atan_at(4'(i));
      end
    end
  end

  // quaternion: axis scaled by the sine, cosine as w
  always_comb begin
    logic signed [17:0] s, c;
    logic signed [34:0] px, py, pz;
    if (cord_q[CordicSteps].up) begin
      c = -cord_q[CordicSteps].y;
      s = cord_q[CordicSteps].x;
    end else begin
      c = cord_q[CordicSteps].x;
      s = cord_q[CordicSteps].y;
    end
    px = 35'(cord_q[CordicSteps].ax * s) + 35'sd8192;
    py = 35'(cord_q[CordicSteps].ay * s) + 35'sd8192;
    pz = 35'(cord_q[CordicSteps].az * s) + 35'sd8192;
    quat_d.x = px[32:14];
    quat_d.y = py[32:14];
    quat_d.z = pz[32:14];
    quat_d.w = 19'(c);
  end

  // squared components
  always_comb begin
    logic signed [37:0] p [4];
    p[0] = quat_q.x * quat_q.x;
    p[1] = quat_q.y * quat_q.y;
    p[2] = quat_q.z * quat_q.z;
    p[3] = quat_q.w * quat_q.w;
    for (int k = 0; k < 4; k++) begin
      sq_d[k] = p[k][32:0];
    end
  end

  // squared norm, then integer square root, two radicand bits per stage
  always_comb begin
    logic [33:0] bitv, trial;
    root_d[0].n   = 34'(sq_q[0]) + 34'(sq_q[1]) + 34'(sq_q[2]) + 34'(sq_q[3]);
    root_d[0].res = '0;
    root_d[0].q   = sqq_q;
    for (int k = 0; k < SqrtSteps; k++) begin
      bitv        = 34'd1 << (32 - 2 * k);
      trial       = root_q[k].res + bitv;
      root_d[k+1] = root_q[k];
      if (root_q[k].n >= trial) begin
        root_d[k+1].n   = root_q[k].n - trial;
        root_d[k+1].res = (root_q[k].res >> 1) + bitv;
      end else begin
        root_d[k+1].res = root_q[k].res >> 1;
      end
    end
  end

  // divider setup: rounded numerator per component
  // then restoring divide, one quotient bit per stage, four lanes
  always_comb begin
    logic [18:0] mag [4];
    logic [17:0] d;
    logic [33:0] dsh;
    d = root_q[SqrtSteps].res[17:0];
    mag[0] = root_q[SqrtSteps].q.x[18] ? 19'(-root_q[SqrtSteps].q.x) : root_q[SqrtSteps].q.x;
    mag[1] = root_q[SqrtSteps].q.y[18] ? 19'(-root_q[SqrtSteps].q.y) : root_q[SqrtSteps].q.y;
    mag[2] = root_q[SqrtSteps].q.z[18] ? 19'(-root_q[SqrtSteps].q.z) : root_q[SqrtSteps].q.z;
    mag[3] = root_q[SqrtSteps].q.w[18] ? 19'(-root_q[SqrtSteps].q.w) : root_q[SqrtSteps].q.w;
    div_d[0].neg  = {root_q[SqrtSteps].q.w[18], root_q[SqrtSteps].q.z[18],
                     root_q[SqrtSteps].q.y[18], root_q[SqrtSteps].q.x[18]};
    div_d[0].d    = d;
    div_d[0].zero = (d == '0);
    for (int k = 0; k < 4; k++) begin
      div_d[0].rem[k] = {1'b0, mag[k], 14'd0} + 34'(d >> 1);
      div_d[0].qt[k]  = '0;
    end
    for (int s = 0; s < DivSteps; s++) begin
      div_d[s+1] = div_q[s];
      dsh = 34'(div_q[s].d) << (DivSteps - 1 - s);
      for (int k = 0; k < 4; k++) begin
        if (div_q[s].rem[k] >= dsh) begin
          div_d[s+1].rem[k] = div_q[s].rem[k] - dsh;
          div_d[s+1].qt[k][DivSteps-1-s] = 1'b1;
        end
      end
    end
  end

  // signed normalized quaternion and the nine doubled products
  always_comb begin
    logic signed [15:0] n [4];
    for (int k = 0; k < 4; k++) begin
      if (div_q[DivSteps].zero) begin
        // zero norm: quaternion is all zero, which gives the identity
        n[k] = '0;
      end else if (div_q[DivSteps].neg[k]) begin
        n[k] = -$signed({1'b0, div_q[DivSteps].qt[k]});
      end else begin
        n[k] = $signed({1'b0, div_q[DivSteps].qt[k]});
      end
    end
    prod_d.xx = 33'(n[0] * n[0]) <<< 1;
    prod_d.yy = 33'(n[1] * n[1]) <<< 1;
    prod_d.zz = 33'(n[2] * n[2]) <<< 1;
    prod_d.xy = 33'(n[0] * n[1]) <<< 1;
    prod_d.xz = 33'(n[0] * n[2]) <<< 1;
    prod_d.yz = 33'(n[1] * n[2]) <<< 1;
    prod_d.wx = 33'(n[3] * n[0]) <<< 1;
    prod_d.wy = 33'(n[3] * n[1]) <<< 1;
    prod_d.wz = 33'(n[3] * n[2]) <<< 1;
  end

  // matrix entries: round to q1.14 and clamp to plus or minus one
  function automatic logic signed [15:0] to_out(input logic signed [34:0] v);
    logic signed [34:0] r;
    r = (v + 35'sd8192) >>> 14;
    if (r > 35'(OutOne)) begin
      return 16'(OutOne);
    end else if (r < -35'(OutOne)) begin
      return -16'(OutOne);
    end
    return r[15:0];
  endfunction

  always_comb begin
    logic signed [34:0] one;
    one = 35'sd1 <<< (2 * FracBits);
    res_d.m00 = to_out(one - 35'(prod_q.yy) - 35'(prod_q.zz));
    res_d.m01 = to_out(35'(prod_q.xy) - 35'(prod_q.wz));
    res_d.m02 = to_out(35'(prod_q.xz) + 35'(prod_q.wy));
    res_d.m10 = to_out(35'(prod_q.xy) + 35'(prod_q.wz));
    res_d.m11 = to_out(one - 35'(prod_q.xx) - 35'(prod_q.zz));
    res_d.m12 = to_out(35'(prod_q.yz) - 35'(prod_q.wx));
    res_d.m20 = to_out(35'(prod_q.xz) - 35'(prod_q.wy));
    res_d.m21 = to_out(35'(prod_q.yz) + 35'(prod_q.wx));
    res_d.m22 = to_out(one - 35'(prod_q.xx) - 35'(prod_q.yy));
  end

  // payload pipeline, advances every cycle
  always_ff @(posedge clk_i) begin
    cord_q[0] <= cord_d[0];
    for (int i = 1; i <= CordicSteps; i++) begin
      cord_q[i] <= cord_d[i];
    end
    quat_q <= quat_d;
    sq_q   <= sq_d;
    sqq_q  <= quat_q;
    for (int k = 0; k <= SqrtSteps; k++) begin
      root_q[k] <= root_d[k];
    end
    for (int s = 0; s <= DivSteps; s++) begin
      div_q[s] <= div_d[s];
    end
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign done_o   = vld_q[Lat-1];
  assign result_o = res_q;

  // every transfer comes out exactly once, a fixed time later
  `AAR_ASSERT_DLY(a_latency, clk_i, rst_ni, start && !busy, Lat, done_o)
  // diagonal entries m00 and m11 stay within plus or minus one
  `AAR_ASSERT_IMP(a_diag_range, clk_i, rst_ni, done_o,
    (result_o.m00 <= 16'sd16384) && (result_o.m00 >= -16'sd16384) &&
    (result_o.m11 <= 16'sd16384) && (result_o.m11 >= -16'sd16384))
  // a strobe only ever follows a start transfer
  `AAR_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, done_o, $past(start, Lat))

endmodule

// ===== sim/aar_checker.sv =====
// ----------------------------------------------------------------------------
// aar_checker
// predicts the rotation matrix of every start transfer and compares each
// result transfer, entry by entry, with the oldest pending prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aar_checker import aar_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    done_i,
  input  result_t result_i,
  output int      fail_cnt_o,
  output int      pending_o
);

  result_t pending_mats[$];
  int      fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_mats.size();

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unit_scale(longint num, longint unsigned d);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q   = ((mag << FracBits) + (d >> 1)) / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    int     sh;
    longint r;
    sh = 2 * FracBits - 14;
    r  = floor_shr(v + (longint'(1) << (sh - 1)), sh);
    if (r > OutOne) r = OutOne;
    if (r < -OutOne) r = -OutOne;
    return r[15:0];
  endfunction

  // half-angle cordic, quaternion, normalize, expand to the matrix
  function automatic result_t rotation_of(item_t it);
    longint ax, ay, az, x, y, z, dx, dy, sn, cs, qx, qy, qz, qw, one;
    longint unsigned n2, nrm;
    logic   upper;
    result_t m;
    ax    = it.axis_x;
    ay    = it.axis_y;
    az    = it.axis_z;
    upper = it.turn_angle[15];
    z     = longint'({1'b0, it.turn_angle[14:0]}) << 15;
    x     = CordicX0;
    y     = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_at(4'(i));
      end else begin
        x = x + dx; y = y - dy; z = z + atan_at(4'(i));
      end
    end
    if (upper) begin
      cs = -y; sn = x;
    end else begin
      cs = x; sn = y;
    end
    qx = floor_shr(ax * sn + 8192, 14);
    qy = floor_shr(ay * sn + 8192, 14);
    qz = floor_shr(az * sn + 8192, 14);
    qw = cs;
    n2 = qx * qx + qy * qy + qz * qz + qw * qw;
    // zero norm leaves the quaternion as it is, which gives identity
    if (n2 != 0) begin
      nrm = int_sqrt(n2);
      qx  = unit_scale(qx, nrm);
      qy  = unit_scale(qy, nrm);
      qz  = unit_scale(qz, nrm);
      qw  = unit_scale(qw, nrm);
    end
    one   = longint'(1) << (2 * FracBits);
    m.m00 = to_q14(one - 2 * qy * qy - 2 * qz * qz);
    m.m01 = to_q14(2 * qx * qy - 2 * qw * qz);
    m.m02 = to_q14(2 * qx * qz + 2 * qw * qy);
    m.m10 = to_q14(2 * qx * qy + 2 * qw * qz);
    m.m11 = to_q14(one - 2 * qx * qx - 2 * qz * qz);
    m.m12 = to_q14(2 * qy * qz - 2 * qw * qx);
    m.m20 = to_q14(2 * qx * qz - 2 * qw * qy);
    m.m21 = to_q14(2 * qy * qz + 2 * qw * qx);
    m.m22 = to_q14(one - 2 * qx * qx - 2 * qy * qy);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      fail_cnt = 0;
      pending_mats.delete();
    end else begin
      if (done_i) begin
        if (pending_mats.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_mats.pop_front();
          if (result_i.m00 !== want.m00) report_mismatch("m00", result_i.m00, want.m00);
          if (result_i.m01 !== want.m01) report_mismatch("m01", result_i.m01, want.m01);
          if (result_i.m02 !== want.m02) report_mismatch("m02", result_i.m02, want.m02);
          if (result_i.m10 !== want.m10) report_mismatch("m10", result_i.m10, want.m10);
          if (result_i.m11 !== want.m11) report_mismatch("m11", result_i.m11, want.m11);
          if (result_i.m12 !== want.m12) report_mismatch("m12", result_i.m12, want.m12);
          if (result_i.m20 !== want.m20) report_mismatch("m20", result_i.m20, want.m20);
          if (result_i.m21 !== want.m21) report_mismatch("m21", result_i.m21, want.m21);
          if (result_i.m22 !== want.m22) report_mismatch("m22", result_i.m22, want.m22);
        end
      end
      if (start_i && !busy_i) pending_mats.push_back(rotation_of(item_i));
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random axis-angle items with random gaps into the
// rotation matrix pipeline; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import aar_pkg::*;

  localparam int Latency    = 54;
  localparam int StallLimit = 2000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done_o;
  result_t result_o;
  int      fail_cnt;
  int      pending;
  int      idle_cycles;

  axis_angle_to_rotation_matrix dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done_o),
    .result_o (result_o)
  );

  aar_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .item_i     (item),
    .done_i     (done_o),
    .result_i   (result_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one transfer: optional idle gap, then hold start until accepted
  task automatic send_item(item_t it, int gap);
    for (int i = 0; i < gap; i++) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic item_t make_item(int ax, int ay, int az, int ang);
    item_t it;
    it.axis_x     = ax[15:0];
    it.axis_y     = ay[15:0];
    it.axis_z     = az[15:0];
    it.turn_angle = ang[15:0];
    return it;
  endfunction

  // random axis: half moderate values, the rest full-range, extreme or zero ones
  function automatic int rand_axis();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 65535) - 32768;
      1:       return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      2:       return 0;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int gap;
    int burst;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item        = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero axis, zero norm, quarter turns, axis of -1
    send_item(make_item(0, 0, 0, 0), 0);
    send_item(make_item(0, 0, 0, 32768), 0);
    send_item(make_item(0, 0, 0, 12345), 1);
    send_item(make_item(16384, 0, 0, 16384), 0);
    send_item(make_item(0, 16384, 0, 16384), 0);
    send_item(make_item(0, 0, 16384, 16384), 2);
    send_item(make_item(16384, 0, 0, 32768), 0);
    send_item(make_item(0, 16384, 0, 49152), 0);
    send_item(make_item(0, 0, 16384, 65535), 0);
    send_item(make_item(32767, 32767, 32767, 65535), 3);
    send_item(make_item(-32768, -32768, -32768, 32767), 0);
    send_item(make_item(-32768, 0, 0, 8192), 0);
    send_item(make_item(32767, -32768, 1, 1), 0);
    send_item(make_item(1, 0, 0, 32769), 1);
    send_item(make_item(-1, -1, -1, 32767), 0);
    send_item(make_item(100, -200, 300, 0), 0);
    send_item(make_item(9000, 9000, 9000, 21845), 0);
    send_item(make_item(-16384, 16384, -16384, 43690), 0);

    // random, in bursts with and without gaps
    for (int n = 0; n < 800; n++) begin
      if (n % 40 == 0) burst = $urandom_range(0, 2);
      gap = (burst == 0) ? 0 : $urandom_range(0, 3);
      send_item(make_item(rand_axis(), rand_axis(), rand_axis(),
                          $urandom_range(0, 65535)), gap);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
